// ===== design/e2e_profile4m_receive_check_defines.svh =====
// assertion macros shared by the e2e profile 4m receive check
// no dependencies
`ifndef E2E_PROFILE4M_RECEIVE_CHECK_DEFINES_SVH
`define E2E_PROFILE4M_RECEIVE_CHECK_DEFINES_SVH
// property that must hold at every edge out of reset
`define E2E_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// implication checked from the next edge
`define E2E_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== design/e2e4m_pkg.sv =====
// shared types, constants and crc function for the e2e profile 4m receive check
// no dependencies
package e2e4m_pkg;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY_R = 32'hC8DF_352F;
	localparam logic [15:0] COUNTER_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_OKSOMELOST = 3'd1, ST_ERROR = 3'd2,
		ST_REPEATED = 3'd3, ST_NONEWDATA = 3'd4, ST_WRONGSEQ = 3'd5
	} chk_status_t;

	typedef enum logic [2:0] {
		GEN_OK = 3'd0, GEN_REPEATED = 3'd1, GEN_WRONGSEQ = 3'd2,
		GEN_ERROR = 3'd3, GEN_NONEWDATA = 3'd4
	} gen_status_t;

	typedef enum logic [2:0] {
		REG_OFFSET = 3'd0, REG_DATA_ID = 3'd1, REG_MAX_DELTA = 3'd2,
		REG_MIN_LEN = 3'd3, REG_MAX_LEN = 3'd4, REG_SINK_ROLE = 3'd5
	} reg_idx_t;

	// one finished message or no-data request, as handed to the back part
	typedef struct packed {
		logic        nodata;
		logic        nodata_len_bad;
		logic        len_bad;
		logic        frame_err;
		logic        hdr_match;
		logic [27:0] rx_src;
		logic [15:0] rx_cnt;
	} job_t;

	// byte-wide reflected crc update
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY_R) : (c >> 1);
		end
		return c;
	endfunction
endpackage

// ===== design/e2e4m_front.sv =====
// front part: parses the header, runs the crc and classifies each finished message
// depends on e2e4m_pkg
module e2e4m_front import e2e4m_pkg::*; #(
	parameter int MAX_MESSAGE_BYTES = 4096,
	parameter int PW = $clog2(MAX_MESSAGE_BYTES + 2)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        no_data,
	input  logic [12:0] message_length,
	input  logic [27:0] expected_source_id,
	input  logic        expected_msg_type,
	input  logic        expected_msg_result,
	input  logic [11:0] header_offset_bytes,
	input  logic [31:0] data_id,
	input  logic [12:0] min_length_bytes,
	input  logic [12:0] max_length_bytes,
	input  logic        sink_role,
	output logic        job_valid,
	output job_t        job
);
	logic [PW-1:0] pos_q;
	logic [31:0]   crc_q;
	logic [15:0]   hlen_q, hcnt_q;
	logic [31:0]   hid_q, hcrc_q, hsrc_q;
	logic [12:0]   exp_len_q;
	logic [27:0]   exp_src_q;
	logic          exp_type_q, exp_res_q;

	logic          first;
	logic [12:0]   cur_len;
	logic [27:0]   cur_src;
	logic          cur_type, cur_res;
	logic [PW:0]   rel;
	logic          in_hdr, in_crc;
	logic [31:0]   crc_n;
	logic [15:0]   hlen_n, hcnt_n;
	logic [31:0]   hid_n, hcrc_n, hsrc_n;
	logic [PW-1:0] pos_n;
	logic          len_bad;
	logic [27:0]   rsrc;
	logic          rtype, rres;

	assign first    = (pos_q == '0);
	assign cur_len  = first ? message_length : exp_len_q;
	assign cur_src  = first ? expected_source_id : exp_src_q;
	assign cur_type = first ? expected_msg_type : exp_type_q;
	assign cur_res  = first ? expected_msg_result : exp_res_q;

	// header window
	assign rel    = {1'b0, pos_q} - (PW+1)'(header_offset_bytes);
	assign in_hdr = ({1'b0, pos_q} >= (PW+1)'(header_offset_bytes)) && (rel < (PW+1)'(16));
	assign in_crc = in_hdr && (rel >= (PW+1)'(8)) && (rel < (PW+1)'(12));

	always_comb begin
		hlen_n = hlen_q; hcnt_n = hcnt_q; hid_n = hid_q; hcrc_n = hcrc_q; hsrc_n = hsrc_q;
		if (in_hdr) begin
			if (rel < (PW+1)'(2))       hlen_n = {hlen_q[7:0], data_byte};
			else if (rel < (PW+1)'(4))  hcnt_n = {hcnt_q[7:0], data_byte};
			else if (rel < (PW+1)'(8))  hid_n  = {hid_q[23:0], data_byte};
			else if (rel < (PW+1)'(12)) hcrc_n = {hcrc_q[23:0], data_byte};
			else                        hsrc_n = {hsrc_q[23:0], data_byte};
		end
		crc_n = in_crc ? crc_q : crc_byte(crc_q, data_byte);
		pos_n = (pos_q < PW'(MAX_MESSAGE_BYTES + 1)) ? pos_q + 1'b1 : pos_q;
	end

	// final checks on the last byte
	assign len_bad = (cur_len < min_length_bytes) || (cur_len > max_length_bytes) ||
		(32'(cur_len) > 32'(MAX_MESSAGE_BYTES));
	assign rsrc  = hsrc_n[27:0];
	assign rtype = (hsrc_n[31:30] != 2'd0);
	assign rres  = (hsrc_n[29:28] != 2'd0);

	always_comb begin
		job_valid = in_valid && (no_data || last_byte);
		job.nodata = no_data;
		job.nodata_len_bad = (message_length != '0);
		job.len_bad = len_bad;
		job.frame_err = (14'(cur_len) < 14'(header_offset_bytes) + 14'd16) ||
			(32'(pos_n) != 32'(cur_len));
		job.hdr_match = ((crc_n ^ CRC_INIT) == hcrc_n) && (hid_n == data_id) &&
			(hlen_n == 16'(cur_len)) && (sink_role || rsrc == cur_src) &&
			(rtype == cur_type) && (rres == cur_res);
		job.rx_src = (no_data || len_bad || !sink_role) ? 28'd0 : rsrc;
		job.rx_cnt = (no_data || len_bad) ? 16'd0 : hcnt_n;
	end

	// message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; crc_q <= CRC_INIT;
			hlen_q <= '0; hcnt_q <= '0; hid_q <= '0; hcrc_q <= '0; hsrc_q <= '0;
			exp_len_q <= '0; exp_src_q <= '0; exp_type_q <= 1'b0; exp_res_q <= 1'b0;
		end else if (in_valid) begin
			if (no_data || last_byte) begin
				pos_q <= '0; crc_q <= CRC_INIT;
				hlen_q <= '0; hcnt_q <= '0; hid_q <= '0; hcrc_q <= '0; hsrc_q <= '0;
			end else begin
				pos_q <= pos_n; crc_q <= crc_n;
				hlen_q <= hlen_n; hcnt_q <= hcnt_n; hid_q <= hid_n;
				hcrc_q <= hcrc_n; hsrc_q <= hsrc_n;
			end
			if (!no_data && first) begin
				exp_len_q <= message_length; exp_src_q <= expected_source_id;
				exp_type_q <= expected_msg_type; exp_res_q <= expected_msg_result;
			end
		end
	end
endmodule

// ===== design/e2e4m_queue.sv =====
// two-entry request queue between front and back parts
// depends on e2e4m_pkg and the assertion macro header
`include "e2e_profile4m_receive_check_defines.svh"
module e2e4m_queue import e2e4m_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	input  job_t wr_job,
	output logic wr_ready,
	output logic rd_valid,
	input  logic rd_ready,
	output job_t rd_job
);
	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_job   = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop  = rd_valid && rd_ready;

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_job;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	`E2E_ASSERT_ALWAYS(a_cnt_range, clk, arst_n, cnt_q <= 2'd2, "queue count overflow")
	`E2E_ASSERT_ALWAYS(a_ptr_cnt, clk, arst_n, (cnt_q == 2'd1) == (wp_q != rp_q), "ptr mismatch")
	`E2E_ASSERT_NEXT(a_full_hold, clk, arst_n, cnt_q == 2'd2 && !pop, cnt_q == 2'd2, "full lost")
endmodule

// ===== design/e2e4m_back.sv =====
// back part: updates counter and status, drives the output register
// depends on e2e4m_pkg
module e2e4m_back import e2e4m_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	input  job_t        job,
	output logic        job_ready,
	input  logic [15:0] max_delta_counter,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        return_code,
	output logic [2:0]  check_status,
	output logic [2:0]  generic_status,
	output logic [27:0] received_source_id,
	output logic [15:0] received_counter
);
	chk_status_t st_q, st_n;
	logic [15:0] last_q, last_n;
	logic        ret;
	logic [15:0] delta;
	gen_status_t gen;
	logic        take;

	assign job_ready = !out_valid || out_ready;
	assign take  = job_valid && job_ready;
	assign delta = job.rx_cnt - last_q;

	// status update
	always_comb begin
		st_n = st_q; last_n = last_q; ret = 1'b0;
		if (job.nodata) begin
			if (job.nodata_len_bad) ret = 1'b1;
			else st_n = ST_NONEWDATA;
		end else if (job.len_bad) begin
			ret = 1'b1;
		end else if (job.frame_err || !job.hdr_match) begin
			st_n = ST_ERROR;
		end else begin
			last_n = job.rx_cnt;
			if (delta > max_delta_counter) st_n = ST_WRONGSEQ;
			else if (delta == 16'd0)       st_n = ST_REPEATED;
			else if (delta == 16'd1)       st_n = ST_OK;
			else                           st_n = ST_OKSOMELOST;
		end
		if (ret) gen = GEN_ERROR;
		else begin
			unique case (st_n)
				ST_OK, ST_OKSOMELOST: gen = GEN_OK;
				ST_REPEATED:          gen = GEN_REPEATED;
				ST_WRONGSEQ:          gen = GEN_WRONGSEQ;
				ST_NONEWDATA:         gen = GEN_NONEWDATA;
				default:              gen = GEN_ERROR;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_ERROR; last_q <= COUNTER_MAX; out_valid <= 1'b0;
		end else begin
			if (take) begin
				st_q <= st_n; last_q <= last_n;
			end
			if (job_ready) out_valid <= job_valid;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (take) begin
			return_code <= ret;
			check_status <= st_n;
			generic_status <= gen;
			received_source_id <= job.rx_src;
			received_counter <= job.rx_cnt;
		end
	end
endmodule

// ===== design/e2e_profile4m_receive_check.sv =====
// top level of the e2e profile 4m receive check
// depends on e2e4m_pkg, e2e4m_front, e2e4m_queue, e2e4m_back
//
// Checks e2e profile 4m protected messages arriving one byte per request on
// s_axis; a result request leaves on m_axis for each last byte or no-data
// request. A byte is taken every cycle unless the queue is full: the
// byte-wide crc update sets the one-cycle rate. A result passes the queue
// and the output register. A two-entry queue lets the input run while the
// output stalls; s_axis_tready drops only when that queue is full.
module e2e_profile4m_receive_check import e2e4m_pkg::*; #(
	parameter int MAX_MESSAGE_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// data_byte[7:0], message_length[20:8], expected_source_id[48:21],
	// expected_msg_type[49], expected_msg_result[50], zero fill
	input  logic [55:0] s_axis_tdata,
	input  logic        s_axis_tlast,  // last_byte
	input  logic        s_axis_tuser,  // no_data
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// return_code[0], check_status[3:1], generic_status[6:4],
	// received_source_id[34:7], received_counter[50:35], zero fill
	output logic [55:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	logic [11:0] offset_q;
	logic [31:0] data_id_q;
	logic [15:0] max_delta_q;
	logic [12:0] min_len_q, max_len_q;
	logic        sink_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0; data_id_q <= '0; max_delta_q <= 16'd1;
			min_len_q <= 13'd16; max_len_q <= 13'd4096; sink_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OFFSET:    offset_q <= cfg_wdata[11:0];
				REG_DATA_ID:   data_id_q <= cfg_wdata;
				REG_MAX_DELTA: max_delta_q <= cfg_wdata[15:0];
				REG_MIN_LEN:   min_len_q <= cfg_wdata[12:0];
				REG_MAX_LEN:   max_len_q <= cfg_wdata[12:0];
				REG_SINK_ROLE: sink_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	logic fr_valid, q_ready, bq_valid, bq_ready, acc;
	job_t fr_job, bq_job;

	assign s_axis_tready = q_ready;
	assign acc = s_axis_tvalid && s_axis_tready;

	e2e4m_front #(.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)) u_front (
		.clk, .arst_n, .in_valid(acc),
		.data_byte(s_axis_tdata[7:0]), .last_byte(s_axis_tlast), .no_data(s_axis_tuser),
		.message_length(s_axis_tdata[20:8]), .expected_source_id(s_axis_tdata[48:21]),
		.expected_msg_type(s_axis_tdata[49]), .expected_msg_result(s_axis_tdata[50]),
		.header_offset_bytes(offset_q), .data_id(data_id_q),
		.min_length_bytes(min_len_q), .max_length_bytes(max_len_q), .sink_role(sink_q),
		.job_valid(fr_valid), .job(fr_job)
	);

	e2e4m_queue u_queue (
		.clk, .arst_n, .wr_valid(fr_valid), .wr_job(fr_job), .wr_ready(q_ready),
		.rd_valid(bq_valid), .rd_ready(bq_ready), .rd_job(bq_job)
	);

	logic        rc;
	logic [2:0]  cs, gs;
	logic [27:0] rs;
	logic [15:0] rcnt;

	e2e4m_back u_back (
		.clk, .arst_n, .job_valid(bq_valid), .job(bq_job), .job_ready(bq_ready),
		.max_delta_counter(max_delta_q), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.return_code(rc), .check_status(cs), .generic_status(gs),
		.received_source_id(rs), .received_counter(rcnt)
	);

	assign m_axis_tdata = {5'd0, rcnt, rs, gs, cs, rc};
endmodule
